>>> rtl/bptm_pkg.sv
// shared types, codes and sizes for the breakpoint table matcher
package bptm_pkg;

  // table geometry
  localparam int unsigned SLOTS  = 16;
  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

  // field widths
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned FILE_W   = 16;
  localparam int unsigned LINE_W   = 20;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 5;

  // stream word widths
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 8;

  // action codes
  localparam logic [ACT_W-1:0] ACT_CHECK = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_NONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STEP    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FAIL    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

  // result slot source
  typedef enum logic [1:0] {
    SLOT_NONE,
    SLOT_HIT,
    SLOT_ADD
  } slot_sel_e;

  // controller to datapath
  typedef struct packed {
    logic                load_in;
    logic                load_out;
    logic                wr_entry;
    logic                clr_table;
    logic                upd_prev;
    logic [STATUS_W-1:0] status;
    slot_sel_e           slot_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] op;
    logic             loc_changed;
    logic             hit;
    logic             full;
    logic             fid_zero;
  } sts_t;

endpackage

>>> rtl/breakpoint_table_match.sv
// top level of the breakpoint table matcher
//
//  channel   direction  tdata                          tuser
//  s_axis    in         [15:0] file_id [35:16] line_no [1:0] action
//  m_axis    out        [4:0] slot                     [2:0] status
//  cfg       in         cfg_wdata_i = step_mode        -
//
// each word is first captured, then executed: the execute step runs the 16 slot
// comparators with the priority encoder and loads the output register
// no new word is taken until the previous word has loaded its result, but a new
// word is taken while the previous result still waits on m_axis;
// the execute step stalls only until that result is taken
// reset empties the table (fill count to zero), zeroes the last location
// and clears step mode; no clearing pass is needed
module breakpoint_table_match (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // step mode register write
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  // input words
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bptm_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // file_id, line_no, zero pad
  input  logic [bptm_pkg::ACT_W-1:0]      s_axis_tuser,   // action
  // result words
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bptm_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // slot, zero pad
  output logic [bptm_pkg::STATUS_W-1:0]   m_axis_tuser    // status
);

  bptm_pkg::cmd_t cmd;
  bptm_pkg::sts_t sts;

  logic [bptm_pkg::SLOT_W-1:0] slot;

  // sequencing and handshakes
  bptm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // table, comparators and result register
  bptm_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .action_i  (s_axis_tuser),
    .file_id_i (s_axis_tdata[bptm_pkg::FILE_W-1:0]),
    .line_no_i (s_axis_tdata[bptm_pkg::FILE_W +: bptm_pkg::LINE_W]),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .status_o  (m_axis_tuser),
    .slot_o    (slot)
  );

  // pad slot up to a whole byte
  assign m_axis_tdata = {{(bptm_pkg::OUT_DATA_W - bptm_pkg::SLOT_W){1'b0}}, slot};

endmodule

>>> rtl/bptm_ctrl.sv
// controller: sequencing, handshakes, step mode register and result selection
module bptm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  input  bptm_pkg::sts_t sts_i,
  output bptm_pkg::cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic step_mode_q;
  logic exec_go;

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = out_valid_q;

  // result can be written once the output register is free or draining
  assign exec_go = (state_q == S_EXEC) && (!out_valid_q || m_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_go) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load_in   = s_ready_o && s_valid_i;
    cmd_o.load_out  = exec_go;
    cmd_o.status    = bptm_pkg::ST_NONE;
    cmd_o.slot_sel  = bptm_pkg::SLOT_NONE;
    case (sts_i.op)
      bptm_pkg::ACT_CHECK: begin
        cmd_o.upd_prev = exec_go;
        if (sts_i.loc_changed) begin
          if (step_mode_q) begin
            cmd_o.status = bptm_pkg::ST_STEP;
          end else if (sts_i.hit) begin
            cmd_o.status   = bptm_pkg::ST_HIT;
            cmd_o.slot_sel = bptm_pkg::SLOT_HIT;
          end
        end
      end
      bptm_pkg::ACT_ADD: begin
        if (sts_i.fid_zero || sts_i.full) begin
          cmd_o.status = bptm_pkg::ST_FAIL;
        end else begin
          cmd_o.status   = bptm_pkg::ST_ADDED;
          cmd_o.slot_sel = bptm_pkg::SLOT_ADD;
          cmd_o.wr_entry = exec_go;
        end
      end
      bptm_pkg::ACT_CLEAR: begin
        cmd_o.status    = bptm_pkg::ST_CLEARED;
        cmd_o.clr_table = exec_go;
      end
      default: begin
        cmd_o.status = bptm_pkg::ST_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      step_mode_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) step_mode_q <= cfg_wdata_i;
    end
  end

endmodule

>>> rtl/bptm_dp.sv
// datapath: input capture, breakpoint table, comparators and output register
module bptm_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bptm_pkg::ACT_W-1:0]    action_i,
  input  logic [bptm_pkg::FILE_W-1:0]   file_id_i,
  input  logic [bptm_pkg::LINE_W-1:0]   line_no_i,
  input  bptm_pkg::cmd_t                cmd_i,
  output bptm_pkg::sts_t                sts_o,
  output logic [bptm_pkg::STATUS_W-1:0] status_o,
  output logic [bptm_pkg::SLOT_W-1:0]   slot_o
);

  logic [bptm_pkg::ACT_W-1:0]  act_q;
  logic [bptm_pkg::FILE_W-1:0] fid_q;
  logic [bptm_pkg::LINE_W-1:0] line_q;

  logic [bptm_pkg::FILE_W-1:0] entry_file_q [bptm_pkg::SLOTS];
  logic [bptm_pkg::LINE_W-1:0] entry_line_q [bptm_pkg::SLOTS];
  logic [bptm_pkg::CNT_W-1:0]  cnt_q;

  logic [bptm_pkg::FILE_W-1:0] prev_file_q;
  logic [bptm_pkg::LINE_W-1:0] prev_line_q;

  logic [bptm_pkg::SLOTS-1:0]  match;
  logic [bptm_pkg::SLOT_W-1:0] hit_slot;
  logic [bptm_pkg::SLOT_W-1:0] add_slot;
  logic [bptm_pkg::SLOT_W-1:0] slot_d;

  // occupied slots form a prefix, so the fill count marks validity
  always_comb begin
    for (int i = 0; i < bptm_pkg::SLOTS; i++) begin
      match[i] = (bptm_pkg::CNT_W'(i) < cnt_q) && (entry_file_q[i] == fid_q)
                 && (entry_line_q[i] == line_q);
    end
  end

  // lowest matching slot wins
  always_comb begin
    hit_slot = '0;
    for (int i = bptm_pkg::SLOTS - 1; i >= 0; i--) begin
      if (match[i]) hit_slot = bptm_pkg::SLOT_W'(i + 1);
    end
  end

  assign add_slot = bptm_pkg::SLOT_W'(cnt_q + bptm_pkg::CNT_W'(1));

  always_comb begin
    case (cmd_i.slot_sel)
      bptm_pkg::SLOT_HIT: slot_d = hit_slot;
      bptm_pkg::SLOT_ADD: slot_d = add_slot;
      default:            slot_d = '0;
    endcase
  end

  assign sts_o.op          = act_q;
  assign sts_o.loc_changed = (fid_q != prev_file_q) || (line_q != prev_line_q);
  assign sts_o.hit         = |match;
  assign sts_o.full        = (cnt_q == bptm_pkg::CNT_W'(bptm_pkg::SLOTS));
  assign sts_o.fid_zero    = (fid_q == '0);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q  <= action_i;
      fid_q  <= file_id_i;
      line_q <= line_no_i;
    end
    if (cmd_i.wr_entry) begin
      entry_file_q[cnt_q[bptm_pkg::IDX_W-1:0]] <= fid_q;
      entry_line_q[cnt_q[bptm_pkg::IDX_W-1:0]] <= line_q;
    end
    if (cmd_i.load_out) begin
      status_o <= cmd_i.status;
      slot_o   <= slot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      prev_file_q <= '0;
      prev_line_q <= '0;
    end else begin
      if (cmd_i.clr_table) begin
        cnt_q <= '0;
      end else if (cmd_i.wr_entry) begin
        cnt_q <= cnt_q + bptm_pkg::CNT_W'(1);
      end
      if (cmd_i.upd_prev) begin
        prev_file_q <= fid_q;
        prev_line_q <= line_q;
      end
    end
  end

endmodule

>>> rtl/bptm_checker.sv
// port-level checks for the breakpoint table matcher, bound to the top level
module bptm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bptm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [bptm_pkg::STATUS_W-1:0]   m_axis_tuser
);

  // a stalled result word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // one word at a time: the cycle after an accept takes nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken during execute");

  // status stays within its codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= bptm_pkg::ST_CLEARED)
    else $error("status code out of range");

  // a slot number comes only with a hit or an add
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata != '0) |->
      (m_axis_tuser == bptm_pkg::ST_HIT) || (m_axis_tuser == bptm_pkg::ST_ADDED))
    else $error("slot without hit or add");

  // hit and add always name a slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser == bptm_pkg::ST_HIT) ||
                      (m_axis_tuser == bptm_pkg::ST_ADDED)) |-> m_axis_tdata != '0)
    else $error("hit or add without slot");

endmodule

bind breakpoint_table_match bptm_checker u_bptm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> tb/breakpoint_result_checker.sv
// result checker for the breakpoint table matcher: watches both streams and predicts each result
`timescale 1ns / 100ps

module breakpoint_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [bptm_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // file_id, line_no, zero pad
  input  logic [bptm_pkg::ACT_W-1:0]      s_axis_tuser,   // action
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [bptm_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // slot, zero pad
  input  logic [bptm_pkg::STATUS_W-1:0]   m_axis_tuser,   // status
  output int                              mismatch_cnt_o,
  output int                              results_owed_o
);

  typedef struct packed {
    logic [bptm_pkg::STATUS_W-1:0] status;
    logic [bptm_pkg::SLOT_W-1:0]   slot;
  } bp_result_t;

  // predicted table, last checked location and step mode
  logic [bptm_pkg::FILE_W-1:0] bkpt_file [bptm_pkg::SLOTS];
  logic [bptm_pkg::LINE_W-1:0] bkpt_line [bptm_pkg::SLOTS];
  logic [bptm_pkg::FILE_W-1:0] last_file;
  logic [bptm_pkg::LINE_W-1:0] last_line;
  logic                        step_on;

  bp_result_t awaited_results [$];
  int         result_idx;

  task automatic predict_word(input logic [bptm_pkg::ACT_W-1:0] act,
                              input logic [bptm_pkg::FILE_W-1:0] fid,
                              input logic [bptm_pkg::LINE_W-1:0] ln,
                              output bp_result_t res);
    int i;
    bit stop;
    res.status = bptm_pkg::ST_NONE;
    res.slot   = '0;
    stop       = 1'b0;
    case (act)
      bptm_pkg::ACT_CHECK: begin
        if (fid != last_file || ln != last_line) begin
          if (step_on) begin
            res.status = bptm_pkg::ST_STEP;
          end else begin
            // scan stops at the first free slot, lowest match wins
            for (i = 0; i < bptm_pkg::SLOTS; i++) begin
              if (!stop && bkpt_file[i] == '0) begin
                stop = 1'b1;
              end else if (!stop && bkpt_file[i] == fid && bkpt_line[i] == ln) begin
                res.status = bptm_pkg::ST_HIT;
                res.slot   = bptm_pkg::SLOT_W'(i + 1);
                stop       = 1'b1;
              end
            end
          end
        end
        last_file = fid;
        last_line = ln;
      end
      bptm_pkg::ACT_ADD: begin
        res.status = bptm_pkg::ST_FAIL;
        if (fid != '0) begin
          for (i = 0; i < bptm_pkg::SLOTS; i++) begin
            if (!stop && bkpt_file[i] == '0) begin
              bkpt_file[i] = fid;
              bkpt_line[i] = ln;
              res.status   = bptm_pkg::ST_ADDED;
              res.slot     = bptm_pkg::SLOT_W'(i + 1);
              stop         = 1'b1;
            end
          end
        end
      end
      bptm_pkg::ACT_CLEAR: begin
        for (i = 0; i < bptm_pkg::SLOTS; i++) begin
          bkpt_file[i] = '0;
          bkpt_line[i] = '0;
        end
        res.status = bptm_pkg::ST_CLEARED;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bp_result_t exp_res;
    if (!rst_ni) begin
      for (int i = 0; i < bptm_pkg::SLOTS; i++) begin
        bkpt_file[i] = '0;
        bkpt_line[i] = '0;
      end
      last_file = '0;
      last_line = '0;
      step_on   = 1'b0;
      awaited_results.delete();
      result_idx     = 0;
      mismatch_cnt_o <= 0;
      results_owed_o <= 0;
    end else begin
      if (cfg_we_i) begin
        step_on = cfg_wdata_i;
      end
      // results first: a result never belongs to a word taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          if (mismatch_cnt_o < 10) begin
            $display("result %0d with none pending: status %0d slot %0d",
                     result_idx, m_axis_tuser, m_axis_tdata);
          end
          mismatch_cnt_o <= mismatch_cnt_o + 1;
        end else begin
          exp_res = awaited_results.pop_front();
          if (m_axis_tuser !== exp_res.status ||
              m_axis_tdata !== bptm_pkg::OUT_DATA_W'(exp_res.slot)) begin
            if (mismatch_cnt_o < 10) begin
              $display("result %0d: expected status %0d slot %0d, got status %0d slot %0d",
                       result_idx, exp_res.status, exp_res.slot,
                       m_axis_tuser, m_axis_tdata);
            end
            mismatch_cnt_o <= mismatch_cnt_o + 1;
          end
        end
        result_idx++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_word(s_axis_tuser, s_axis_tdata[bptm_pkg::FILE_W-1:0],
                     s_axis_tdata[bptm_pkg::FILE_W +: bptm_pkg::LINE_W], exp_res);
        awaited_results.push_back(exp_res);
      end
      results_owed_o <= awaited_results.size();
    end
  end

endmodule

>>> tb/tb_breakpoint_table_match.sv
// testbench top for the breakpoint table matcher: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb_breakpoint_table_match;

  // action code the block must ignore
  localparam logic [bptm_pkg::ACT_W-1:0] ACT_RESERVED = 2'd3;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic                            cfg_wdata_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [bptm_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // file_id, line_no, zero pad
  logic [bptm_pkg::ACT_W-1:0]      s_axis_tuser;   // action
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [bptm_pkg::OUT_DATA_W-1:0] m_axis_tdata;   // slot, zero pad
  logic [bptm_pkg::STATUS_W-1:0]   m_axis_tuser;   // status

  int mismatch_cnt;
  int results_owed;

  // idle chance per cycle, in percent, for the word source and the result sink
  int src_idle_pct;
  int sink_idle_pct;

  breakpoint_table_match uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  breakpoint_result_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .mismatch_cnt_o (mismatch_cnt),
    .results_owed_o (results_owed)
  );

  // 20 ns clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result sink: drops ready at random, one decision per cycle
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // hard limit on run time, far above the slowest legal run
  initial begin
    #(5_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // present one word after a random idle run, hold it until the block takes it;
  // valid is only lowered when a gap is inserted so it is never toggled twice in a step
  task automatic send_word(input logic [bptm_pkg::ACT_W-1:0] act,
                           input logic [bptm_pkg::FILE_W-1:0] fid,
                           input logic [bptm_pkg::LINE_W-1:0] ln);
    int idle_run;
    idle_run = 0;
    while (idle_run < 300 && $urandom_range(99) < src_idle_pct) idle_run++;
    if (idle_run > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle_run) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(bptm_pkg::IN_DATA_W - bptm_pkg::FILE_W - bptm_pkg::LINE_W){1'b0}},
                      ln, fid};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop sending, wait until every predicted result has come back,
  // then give the capture and execute steps some slack
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_owed != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // step mode is only written with the block idle
  task automatic set_step_mode(input logic mode);
    drain_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int                          seg;
    int                          n;
    int                          r;
    logic [bptm_pkg::ACT_W-1:0]  act;
    logic [bptm_pkg::FILE_W-1:0] fid;
    logic [bptm_pkg::LINE_W-1:0] ln;
    logic [bptm_pkg::FILE_W-1:0] last_fid;
    logic [bptm_pkg::LINE_W-1:0] last_ln;

    // every input known from time zero
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= bptm_pkg::ACT_CHECK;
    src_idle_pct  <= 30;
    sink_idle_pct <= 87;
    last_fid       = '0;
    last_ln        = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, step mode off after reset
    send_word(bptm_pkg::ACT_CHECK, 16'd0, 20'd0);         // same as reset location, no break
    send_word(bptm_pkg::ACT_CHECK, 16'd0, 20'd5);         // file id zero, empty table
    send_word(bptm_pkg::ACT_ADD, 16'd0, 20'd7);           // add with file id zero is rejected
    send_word(bptm_pkg::ACT_ADD, 16'hFFFF, 20'hFFFFF);    // slot 1, all ones
    send_word(bptm_pkg::ACT_ADD, 16'd1, 20'd0);           // slot 2
    send_word(bptm_pkg::ACT_ADD, 16'd1, 20'd0);           // duplicate goes to slot 3
    send_word(bptm_pkg::ACT_CHECK, 16'd1, 20'd0);         // lowest match wins
    send_word(bptm_pkg::ACT_CHECK, 16'd1, 20'd0);         // unchanged location, no break
    send_word(bptm_pkg::ACT_CHECK, 16'hFFFF, 20'hFFFFF);  // hit on slot 1
    send_word(ACT_RESERVED, 16'hFFFF, 20'hFFFFF);         // ignored, location kept
    for (n = 1; n <= 13; n++) begin
      send_word(bptm_pkg::ACT_ADD, 16'd2, bptm_pkg::LINE_W'(n));  // fill slots 4..16
    end
    send_word(bptm_pkg::ACT_ADD, 16'd3, 20'd3);           // table full
    send_word(bptm_pkg::ACT_CHECK, 16'd2, 20'd13);        // hit on the last slot
    send_word(bptm_pkg::ACT_CLEAR, 16'd0, 20'd0);
    send_word(bptm_pkg::ACT_CHECK, 16'hFFFF, 20'hFFFFF);  // table gone, no break

    // step mode: any change of location breaks
    set_step_mode(1'b1);
    send_word(bptm_pkg::ACT_CHECK, 16'd7, 20'd7);
    send_word(bptm_pkg::ACT_CHECK, 16'd7, 20'd7);
    last_fid = 16'd7;
    last_ln  = 20'd7;

    // random part: three idle profiles, each with step mode off then on
    for (seg = 0; seg < 6; seg++) begin
      drain_block();
      case (seg / 2)
        0: begin
          src_idle_pct  <= 30;
          sink_idle_pct <= 87;
        end
        1: begin
          src_idle_pct  <= 87;
          sink_idle_pct <= 30;
        end
        default: begin
          src_idle_pct  <= 0;
          sink_idle_pct <= 0;
        end
      endcase
      set_step_mode(seg[0]);
      for (n = 0; n < 280; n++) begin
        // small pools of file ids and lines so checks often land on stored entries
        r = $urandom_range(99);
        if (r < 70) begin
          case ($urandom_range(2))
            0:       fid = 16'd1;
            1:       fid = 16'd2;
            default: fid = 16'hFFFF;
          endcase
        end else if (r < 80) begin
          fid = '0;
        end else begin
          fid = bptm_pkg::FILE_W'($urandom_range(16'hFFFF));
        end
        r = $urandom_range(99);
        if (r < 75) begin
          ln = bptm_pkg::LINE_W'($urandom_range(5));
        end else if (r < 80) begin
          ln = 20'hFFFFF;
        end else begin
          ln = bptm_pkg::LINE_W'($urandom_range(20'hFFFFF));
        end
        r = $urandom_range(99);
        if (r < 55) begin
          act = bptm_pkg::ACT_CHECK;
        end else if (r < 85) begin
          act = bptm_pkg::ACT_ADD;
        end else if (r < 88) begin
          act = bptm_pkg::ACT_CLEAR;
        end else if (r < 91) begin
          act = ACT_RESERVED;
        end else begin
          // repeat the last checked location
          act = bptm_pkg::ACT_CHECK;
          fid = last_fid;
          ln  = last_ln;
        end
        if (act == bptm_pkg::ACT_CHECK) begin
          last_fid = fid;
          last_ln  = ln;
        end
        send_word(act, fid, ln);
      end
    end

    // step mode back off, then let everything drain
    set_step_mode(1'b0);
    drain_block();

    if (mismatch_cnt == 0 && results_owed == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
